// ===== hw/rtl/ntt_butterfly_stage_top_assert.svh =====
// ----------------------------------------------------------------------------
// ntt butterfly stage assertion macros
// Concurrent assertion wrappers shared by the stage modules.
// ----------------------------------------------------------------------------
`ifndef NTT_BUTTERFLY_STAGE_TOP_ASSERT_SVH
`define NTT_BUTTERFLY_STAGE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked while reset is released
`define NTT_BFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ntt_bfs assertion failed");

// property checked on every edge, reset included
`define NTT_BFS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ntt_bfs assertion failed");

`else

`define NTT_BFS_ASSERT(lbl, clk, rst_n, prop)
`define NTT_BFS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/ntt_bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ntt_bfs_pkg
// Shared widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package ntt_bfs_pkg;

    localparam int DATA_W          = 64;
    localparam int HALF_W          = 17;
    localparam int MAX_HALF_LENGTH = 65536;
    localparam int CNT_W           = $clog2(DATA_W);
    localparam int ADDR_W          = 5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_ROOT_STEP = 2'd1;
    localparam logic [1:0] REG_HALF_LEN  = 2'd2;
    localparam logic [1:0] REG_NONE      = 2'd3;

    // operations of the shared modular unit
    typedef enum logic [2:0] {
        OP_RED_U,
        OP_RED_V,
        OP_MUL_T,
        OP_RED_RS,
        OP_MUL_W
    } t_op;

    typedef struct packed {
        logic accept;
        logic load;
        logic step_dbl;
        logic use_bit;
        logic step_add;
        logic shift;
        logic store;
        t_op  op;
        logic out_wr;
        logic last;
        logic w_one;
    } t_cmd;

    typedef struct packed {
        logic sh_msb;
    } t_sts;

endpackage

// ===== hw/rtl/ntt_bfs_if.sv =====
// ----------------------------------------------------------------------------
// ntt_bfs channel interfaces
// Valid/ready channels for butterfly pairs and butterfly results.
// ----------------------------------------------------------------------------
interface ntt_bfs_pair_if;
    logic        valid;
    logic        ready;
    logic [63:0] even_value;
    logic [63:0] odd_value;

    modport source (output valid, output even_value, output odd_value, input ready);
    modport sink   (input valid, input even_value, input odd_value, output ready);
endinterface

interface ntt_bfs_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] sum_value;
    logic [63:0] diff_value;
    logic        block_end;
    logic        out_of_range;

    modport source (output valid, output sum_value, output diff_value,
                    output block_end, output out_of_range, input ready);
    modport sink   (input valid, input sum_value, input diff_value,
                    input block_end, input out_of_range, output ready);
endinterface

// ===== hw/rtl/ntt_bfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntt_bfs_ctrl
// Sequencer: runs reductions and multiplies on the datapath, counts pairs.
// ----------------------------------------------------------------------------
`include "ntt_butterfly_stage_top_assert.svh"

module ntt_bfs_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_restart,
    input  logic [ntt_bfs_pkg::HALF_W-1:0] i_half,
    input  ntt_bfs_pkg::t_sts              i_sts,
    output ntt_bfs_pkg::t_cmd              o_cmd
);
    import ntt_bfs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DBL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        r_state, n_state;
    t_op               r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [HALF_W-1:0] r_pair, n_pair;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic              is_mul;
    logic              out_go;
    logic [HALF_W:0]   pair_inc;

    assign is_mul   = (r_op == OP_MUL_T) || (r_op == OP_MUL_W);
    assign out_go   = !r_out_valid || i_out_ready;
    assign pair_inc = {1'b0, r_pair} + {{HALF_W{1'b0}}, 1'b1};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_pair      = r_pair;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.last  = r_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_restart) begin
            n_pair      = '0;
            o_cmd.w_one = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last       = (pair_inc >= {1'b0, i_half});
                    n_op         = OP_RED_U;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = S_DBL;
            end
            S_DBL: begin
                o_cmd.step_dbl = 1'b1;
                if (is_mul) begin
                    n_state = S_ADD;
                end else begin
                    o_cmd.use_bit = 1'b1;
                    o_cmd.shift   = 1'b1;
                    n_cnt         = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        n_state = S_STORE;
                    end
                end
            end
            S_ADD: begin
                o_cmd.step_add = i_sts.sh_msb;
                o_cmd.shift    = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = S_STORE;
                end else begin
                    n_state = S_DBL;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                case (r_op)
                    OP_RED_U: begin
                        n_op    = OP_RED_V;
                        n_state = S_LOAD;
                    end
                    OP_RED_V: begin
                        n_op    = OP_MUL_T;
                        n_state = S_LOAD;
                    end
                    OP_MUL_T: n_state = S_OUT;
                    OP_RED_RS: begin
                        n_op    = OP_MUL_W;
                        n_state = S_LOAD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_go) begin
                    o_cmd.out_wr = 1'b1;
                    n_out_valid  = 1'b1;
                    if (r_last) begin
                        o_cmd.w_one = 1'b1;
                        n_pair      = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_pair  = pair_inc[HALF_W-1:0];
                        n_op    = OP_RED_RS;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RED_U;
            r_cnt       <= '0;
            r_pair      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_pair      <= n_pair;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    `NTT_BFS_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid) |=> (r_state == S_LOAD))
    `NTT_BFS_ASSERT(a_pair_in_block, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_pair < i_half))
    `NTT_BFS_ASSERT(a_out_write_sets_valid, i_clk, i_rst_n, o_cmd.out_wr |=> r_out_valid)
endmodule

// ===== hw/rtl/ntt_bfs_dp.sv =====
// ----------------------------------------------------------------------------
// ntt_bfs_dp
// Operand registers, bit-serial modular add/double unit, butterfly output.
// ----------------------------------------------------------------------------
`include "ntt_butterfly_stage_top_assert.svh"

module ntt_bfs_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ntt_bfs_pkg::t_cmd              i_cmd,
    output ntt_bfs_pkg::t_sts              o_sts,
    input  logic [ntt_bfs_pkg::DATA_W-1:0] i_m,
    input  logic [ntt_bfs_pkg::DATA_W-1:0] i_root_step,
    input  logic [ntt_bfs_pkg::DATA_W-1:0] i_even,
    input  logic [ntt_bfs_pkg::DATA_W-1:0] i_odd,
    output logic [ntt_bfs_pkg::DATA_W-1:0] o_sum,
    output logic [ntt_bfs_pkg::DATA_W-1:0] o_diff,
    output logic                           o_block_end,
    output logic                           o_out_of_range
);
    import ntt_bfs_pkg::*;

    logic [DATA_W-1:0] r_u, r_v, r_t, r_rs, r_w;
    logic [DATA_W-1:0] r_sh, r_a, r_acc, n_acc;
    logic [DATA_W-1:0] r_sum, r_diff;
    logic              r_oor, r_blk, r_oor_out;
    logic [DATA_W:0]   step_sum;
    logic [DATA_W:0]   m_ext;
    logic [DATA_W:0]   bf_sum;
    logic [DATA_W-1:0] bf_sum_red, bf_diff;

    assign m_ext        = {1'b0, i_m};
    assign o_sts.sh_msb = r_sh[DATA_W-1];

    // one modular step: double plus bit, or add the operand, then reduce
    always_comb begin
        if (i_cmd.step_add) begin
            step_sum = {1'b0, r_acc} + {1'b0, r_a};
        end else begin
            step_sum = {r_acc, i_cmd.use_bit & r_sh[DATA_W-1]};
        end
        if (step_sum >= m_ext) begin
            n_acc = DATA_W'(step_sum - m_ext);
        end else begin
            n_acc = step_sum[DATA_W-1:0];
        end
    end

    // butterfly sum and difference
    always_comb begin
        bf_sum = {1'b0, r_u} + {1'b0, r_t};
        if (bf_sum >= m_ext) begin
            bf_sum_red = DATA_W'(bf_sum - m_ext);
        end else begin
            bf_sum_red = bf_sum[DATA_W-1:0];
        end
        if (r_u >= r_t) begin
            bf_diff = r_u - r_t;
        end else begin
            bf_diff = r_u - r_t + i_m;
        end
    end

    // twiddle register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= DATA_W'(1);
        end else if (i_cmd.w_one) begin
            r_w <= DATA_W'(1);
        end else if (i_cmd.store && i_cmd.op == OP_MUL_W) begin
            r_w <= r_acc;
        end
    end

    // operand, accumulator and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_u   <= i_even;
            r_v   <= i_odd;
            r_oor <= (i_even >= i_m) || (i_odd >= i_m);
        end
        if (i_cmd.load) begin
            r_acc <= '0;
            case (i_cmd.op)
                OP_RED_U:  r_sh <= r_u;
                OP_RED_V:  r_sh <= r_v;
                OP_MUL_T: begin
                    r_sh <= r_w;
                    r_a  <= r_v;
                end
                OP_RED_RS: r_sh <= i_root_step;
                OP_MUL_W: begin
                    r_sh <= r_rs;
                    r_a  <= r_w;
                end
                default:   r_sh <= r_u;
            endcase
        end else begin
            if (i_cmd.step_dbl || i_cmd.step_add) begin
                r_acc <= n_acc;
            end
            if (i_cmd.shift) begin
                r_sh <= {r_sh[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.store) begin
            case (i_cmd.op)
                OP_RED_U:  r_u  <= r_acc;
                OP_RED_V:  r_v  <= r_acc;
                OP_MUL_T:  r_t  <= r_acc;
                OP_RED_RS: r_rs <= r_acc;
                default:   r_t  <= r_t;
            endcase
        end
        if (i_cmd.out_wr) begin
            r_sum     <= bf_sum_red;
            r_diff    <= bf_diff;
            r_blk     <= i_cmd.last;
            r_oor_out <= r_oor;
        end
    end

    assign o_sum          = r_sum;
    assign o_diff         = r_diff;
    assign o_block_end    = r_blk;
    assign o_out_of_range = r_oor_out;

    `NTT_BFS_ASSERT(a_acc_reduced, i_clk, i_rst_n, (i_cmd.step_dbl || i_cmd.step_add) |-> (r_acc < i_m))
    `NTT_BFS_ASSERT(a_twiddle_reduced, i_clk, i_rst_n, r_w < i_m)
    `NTT_BFS_ASSERT(a_u_reduced, i_clk, i_rst_n, (i_cmd.store && i_cmd.op == OP_RED_U) |=> (r_u < i_m))
endmodule

// ===== hw/rtl/ntt_butterfly_stage_top.sv =====
// A new pair is taken only once the last one is done, which includes the twiddle update on
// all but a block's last pair; output stalls hold it too. The bit-serial modular unit does
// one 65-bit add and reduce per cycle: 64 steps per reduction, 128 per modular multiply
// (a double and an add for each bit).
// Reset: synchronous active low; twiddle 1, pair count 0, modulus 2, step 1, half length 1.
// ----------------------------------------------------------------------------
// ntt_butterfly_stage_top
// Radix-2 butterfly stage with configuration registers and twiddle tracking.
// ----------------------------------------------------------------------------
module ntt_butterfly_stage_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ntt_bfs_pair_if.sink                   i_pair,
    ntt_bfs_res_if.source                  o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntt_bfs_pkg::ADDR_W-1:0] paddr,
    input  logic [ntt_bfs_pkg::DATA_W-1:0] pwdata,
    output logic [ntt_bfs_pkg::DATA_W-1:0] prdata,
    output logic                           pready
);
    import ntt_bfs_pkg::*;

    logic [DATA_W-1:0] r_modulus, r_root_step;
    logic [HALF_W-1:0] r_half;
    logic [DATA_W-1:0] m_eff;
    logic [HALF_W-1:0] h_eff;
    logic [1:0]        reg_idx;
    logic              wr_en, restart;
    t_cmd              cmd;
    t_sts              sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign restart = wr_en && (reg_idx != REG_NONE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= DATA_W'(2);
            r_root_step <= DATA_W'(1);
            r_half      <= HALF_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODULUS:   r_modulus   <= pwdata;
                REG_ROOT_STEP: r_root_step <= pwdata;
                REG_HALF_LEN:  r_half      <= pwdata[HALF_W-1:0];
                default:       r_half      <= r_half;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_MODULUS:   prdata = r_modulus;
            REG_ROOT_STEP: prdata = r_root_step;
            REG_HALF_LEN:  prdata = {{(DATA_W-HALF_W){1'b0}}, r_half};
            default:       prdata = '0;
        endcase
    end

    // effective modulus and block length
    always_comb begin
        m_eff = (r_modulus < DATA_W'(2)) ? DATA_W'(2) : r_modulus;
        if (r_half == '0) begin
            h_eff = HALF_W'(1);
        end else if (32'(r_half) > MAX_HALF_LENGTH) begin
            h_eff = HALF_W'(MAX_HALF_LENGTH);
        end else begin
            h_eff = r_half;
        end
    end

    ntt_bfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pair.valid),
        .o_in_ready  (i_pair.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_restart   (restart),
        .i_half      (h_eff),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ntt_bfs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_m            (m_eff),
        .i_root_step    (r_root_step),
        .i_even         (i_pair.even_value),
        .i_odd          (i_pair.odd_value),
        .o_sum          (o_res.sum_value),
        .o_diff         (o_res.diff_value),
        .o_block_end    (o_res.block_end),
        .o_out_of_range (o_res.out_of_range)
    );
endmodule
